### rtl/core/twp_pkg.sv
`timescale 1ns / 1ps

package twp_pkg;

    localparam int MAX_POINTS_DEF = 256;

    localparam int TIME_W  = 32;
    localparam int COORD_W = 16;
    localparam int VEL_W   = 17;
    localparam int OP_W    = 3;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 32;
    localparam int ENTRY_W = TIME_W + 2 * COORD_W;

    localparam logic [OP_W-1:0] OP_START   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_OFS = 3'd2;
    localparam logic [OP_W-1:0] OP_END     = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

    localparam logic [CFG_AW-1:0] REG_PLAYBACK_START = 2'd0;
    localparam logic [CFG_AW-1:0] REG_ADDED_OFFSET   = 2'd1;
    localparam logic [CFG_AW-1:0] REG_VELOCITY_LAG   = 2'd2;

    localparam logic [31:0] PLAYBACK_START_RST = 32'd0;
    localparam logic [15:0] ADDED_OFFSET_RST   = 16'd100;
    localparam logic [15:0] VELOCITY_LAG_RST   = 16'd90;

endpackage

### rtl/core/twp_ram.sv
`timescale 1ns / 1ps

module twp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/twp_lerp.sv
`timescale 1ns / 1ps

// a + floor((2*(b-a)*part + whole) / (2*whole)), later point when whole is zero
module twp_lerp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] a,
    input  logic signed [15:0] b,
    input  logic [31:0]        part,
    input  logic [31:0]        whole,
    output logic               done,
    output logic signed [15:0] result
);

    typedef enum logic [2:0] {L_IDLE, L_MUL, L_NUM, L_DIV, L_FIN} lstate_t;

    lstate_t            state_reg;
    logic signed [15:0] a_reg;
    logic signed [15:0] b_reg;
    logic [15:0]        mag_reg;
    logic               negd_reg;
    logic               negn_reg;
    logic               zero_reg;
    logic [31:0]        part_reg;
    logic [31:0]        whole_reg;
    logic [47:0]        prod_reg;
    logic [49:0]        rem_reg;
    logic [49:0]        div_reg;
    logic [17:0]        q_reg;
    logic [4:0]         cnt_reg;
    logic               done_reg;
    logic signed [15:0] result_reg;

    logic signed [16:0] diff;
    logic [48:0]        twice;
    logic [49:0]        whole_ext;
    logic [49:0]        twice_ext;
    logic signed [18:0] fq;

    assign diff      = {b[15], b} - {a[15], a};
    assign twice     = {prod_reg, 1'b0};
    assign whole_ext = {18'd0, whole_reg};
    assign twice_ext = {1'b0, twice};
    assign fq        = negn_reg ? -($signed({1'b0, q_reg}) + 19'(rem_reg != '0))
                                : $signed({1'b0, q_reg});
    assign done      = done_reg;
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= a;
                        b_reg     <= b;
                        negd_reg  <= diff[16];
                        mag_reg   <= diff[16] ? 16'(-diff) : diff[15:0];
                        part_reg  <= part;
                        whole_reg <= whole;
                        zero_reg  <= (whole == '0);
                        state_reg <= L_MUL;
                    end
                end
                L_MUL:
                begin
                    prod_reg  <= 48'(mag_reg) * 48'(part_reg);
                    state_reg <= zero_reg ? L_FIN : L_NUM;
                end
                L_NUM:
                begin
                    if (!negd_reg)
                    begin
                        rem_reg  <= twice_ext + whole_ext;
                        negn_reg <= 1'b0;
                    end
                    else if (twice_ext > whole_ext)
                    begin
                        rem_reg  <= twice_ext - whole_ext;
                        negn_reg <= 1'b1;
                    end
                    else
                    begin
                        rem_reg  <= whole_ext - twice_ext;
                        negn_reg <= 1'b0;
                    end
                    div_reg   <= {whole_reg, 18'd0};
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= L_DIV;
                end
                L_DIV:
                begin
                    if (rem_reg >= div_reg)
                    begin
                        rem_reg <= rem_reg - div_reg;
                        q_reg   <= {q_reg[16:0], 1'b1};
                    end
                    else
                    begin
                        q_reg <= {q_reg[16:0], 1'b0};
                    end
                    div_reg <= div_reg >> 1;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd17)
                    begin
                        state_reg <= L_FIN;
                    end
                end
                L_FIN:
                begin
                    result_reg <= zero_reg ? b_reg : 16'($signed({{3{a_reg[15]}}, a_reg}) + fq);
                    done_reg   <= 1'b1;
                    state_reg  <= L_IDLE;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/timed_waypoint_playback.sv
`timescale 1ns / 1ps

// Start, add, end, unused ops and ticks with no drawing: result in the cycle after the
// transaction, back to back.
// Tick: duration read, modulo fold when the time is past the duration, lagged time, table scan
//       and up to 4 jobs on the shared interpolation divider; busy meanwhile.
// Result strobe done is high for one cycle; the receiver cannot stall.
// Reset clears control state and config registers; the point table is not cleared.
module timed_waypoint_playback #(
    parameter int MAX_POINTS = twp_pkg::MAX_POINTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [twp_pkg::OP_W-1:0]           op,
    input  logic [twp_pkg::TIME_W-1:0]         now,
    input  logic signed [twp_pkg::COORD_W-1:0] x,
    input  logic signed [twp_pkg::COORD_W-1:0] y,
    output logic                               done,
    output logic signed [twp_pkg::COORD_W-1:0] pos_x,
    output logic signed [twp_pkg::COORD_W-1:0] pos_y,
    output logic signed [twp_pkg::VEL_W-1:0]   vel_x,
    output logic signed [twp_pkg::VEL_W-1:0]   vel_y,
    output logic                               have_drawing,
    output logic                               status,
    input  logic                               cfg_we,
    input  logic [twp_pkg::CFG_AW-1:0]         cfg_addr,
    input  logic [twp_pkg::CFG_DW-1:0]         cfg_wdata
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;
    localparam int EW = twp_pkg::ENTRY_W;

    typedef enum logic [2:0] {S_IDLE, S_DUR, S_MOD, S_TP, S_SCAN, S_LGO, S_LWAIT} state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic               recording_reg;
    logic [31:0]        rec_start_reg;
    logic [31:0]        pb_start_reg;
    logic [15:0]        offset_reg;
    logic [15:0]        lag_reg;

    logic signed [33:0] t_reg;
    logic signed [33:0] tp_reg;
    logic [31:0]        dur_reg;
    logic [31:0]        modv_reg;
    logic [31:0]        rem_reg;
    logic [4:0]         mcnt_reg;

    logic [CW-1:0]      scan_reg;
    logic               dvld_reg;
    logic               hprev_reg;
    logic [EW-1:0]      prev_reg;

    logic               found_reg [2];
    logic [31:0]        mpart_reg [2];
    logic [31:0]        mwhole_reg [2];
    logic [15:0]        ma_x_reg [2];
    logic [15:0]        ma_y_reg [2];
    logic [15:0]        mb_x_reg [2];
    logic [15:0]        mb_y_reg [2];
    logic [15:0]        res_reg [4];
    logic [1:0]         job_reg;

    logic               done_reg;
    logic [15:0]        pos_x_reg;
    logic [15:0]        pos_y_reg;
    logic [16:0]        vel_x_reg;
    logic [16:0]        vel_y_reg;
    logic               hd_reg;
    logic               status_reg;

    logic               accept;
    logic               room;
    logic               is_add;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [EW-1:0]      ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [EW-1:0]      ram_rdata;
    logic [31:0]        add_time;
    logic               drawing;

    logic [32:0]        rem_sh;
    logic [32:0]        rem_new;
    logic [31:0]        seg_t0;
    logic [31:0]        seg_t1;
    logic signed [33:0] seg_t0_s;
    logic signed [33:0] seg_t1_s;
    logic signed [33:0] tp_calc;
    logic               hit [2];
    logic signed [33:0] tsel [2];

    logic               l_start;
    logic               l_done;
    logic signed [15:0] l_result;
    logic               jsel;
    logic               jy;

    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);
    assign room    = (count_reg < CW'(MAX_POINTS));
    assign is_add  = (op == twp_pkg::OP_ADD) || (op == twp_pkg::OP_ADD_OFS);
    assign drawing = !recording_reg && (count_reg >= CW'(2));
    assign add_time = (now - rec_start_reg)
                    + ((op == twp_pkg::OP_ADD_OFS) ? {16'd0, offset_reg} : 32'd0);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = {add_time, y, x};
        if (accept && (op == twp_pkg::OP_START))
        begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {32'd0, y, x};
        end
        else if (accept && is_add && room)
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = (state_reg == S_SCAN) ? scan_reg[AW-1:0]
                                             : AW'(count_reg - CW'(1));

    twp_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rem_sh  = {rem_reg, modv_reg[31]};
    assign rem_new = (rem_sh >= {1'b0, dur_reg}) ? rem_sh - {1'b0, dur_reg} : rem_sh;
    assign tp_calc = t_reg - $signed({18'd0, lag_reg});

    assign seg_t0   = prev_reg[63:32];
    assign seg_t1   = ram_rdata[63:32];
    assign seg_t0_s = $signed({2'b00, seg_t0});
    assign seg_t1_s = $signed({2'b00, seg_t1});
    assign tsel[0]  = t_reg;
    assign tsel[1]  = tp_reg;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            hit[k] = (tsel[k] >= seg_t0_s) && (tsel[k] <= seg_t1_s);
        end
    end

    assign jsel    = job_reg[1];
    assign jy      = job_reg[0];
    assign l_start = (state_reg == S_LGO) && found_reg[jsel];

    twp_lerp u_lerp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (l_start),
        .a      (jy ? ma_y_reg[jsel] : ma_x_reg[jsel]),
        .b      (jy ? mb_y_reg[jsel] : mb_x_reg[jsel]),
        .part   (mpart_reg[jsel]),
        .whole  (mwhole_reg[jsel]),
        .done   (l_done),
        .result (l_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            recording_reg <= 1'b0;
            rec_start_reg <= '0;
            pb_start_reg  <= twp_pkg::PLAYBACK_START_RST;
            offset_reg    <= twp_pkg::ADDED_OFFSET_RST;
            lag_reg       <= twp_pkg::VELOCITY_LAG_RST;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    twp_pkg::REG_PLAYBACK_START: pb_start_reg <= cfg_wdata;
                    twp_pkg::REG_ADDED_OFFSET:   offset_reg   <= cfg_wdata[15:0];
                    twp_pkg::REG_VELOCITY_LAG:   lag_reg      <= cfg_wdata[15:0];
                    default:                     ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        pos_x_reg  <= '0;
                        pos_y_reg  <= '0;
                        vel_x_reg  <= '0;
                        vel_y_reg  <= '0;
                        status_reg <= 1'b0;
                        hd_reg     <= drawing;
                        if (op == twp_pkg::OP_START)
                        begin
                            count_reg     <= CW'(1);
                            recording_reg <= 1'b1;
                            rec_start_reg <= now;
                            hd_reg        <= 1'b0;
                            done_reg      <= 1'b1;
                        end
                        else if (is_add)
                        begin
                            if (room)
                            begin
                                count_reg <= count_reg + CW'(1);
                                hd_reg    <= !recording_reg && (count_reg >= CW'(1));
                            end
                            else
                            begin
                                status_reg <= 1'b1;
                            end
                            done_reg <= 1'b1;
                        end
                        else if (op == twp_pkg::OP_END)
                        begin
                            recording_reg <= 1'b0;
                            hd_reg        <= (count_reg >= CW'(2));
                            done_reg      <= 1'b1;
                        end
                        else if ((op == twp_pkg::OP_TICK) && drawing)
                        begin
                            t_reg     <= $signed({2'b00, now}) - $signed({2'b00, pb_start_reg});
                            state_reg <= S_DUR;
                        end
                        else
                        begin
                            done_reg <= 1'b1;
                        end
                    end
                end
                S_DUR:
                begin
                    dur_reg <= ram_rdata[63:32];
                    if ((ram_rdata[63:32] != '0) &&
                        (t_reg > $signed({2'b00, ram_rdata[63:32]})))
                    begin
                        modv_reg  <= t_reg[31:0] - 32'd1;
                        rem_reg   <= '0;
                        mcnt_reg  <= '0;
                        state_reg <= S_MOD;
                    end
                    else
                    begin
                        state_reg <= S_TP;
                    end
                end
                S_MOD:
                begin
                    rem_reg  <= rem_new[31:0];
                    modv_reg <= modv_reg << 1;
                    mcnt_reg <= mcnt_reg + 5'd1;
                    if (mcnt_reg == 5'd31)
                    begin
                        t_reg     <= $signed({2'b00, rem_new[31:0]}) + 34'sd1;
                        state_reg <= S_TP;
                    end
                end
                S_TP:
                begin
                    tp_reg       <= tp_calc[33] ? '0 : tp_calc;
                    scan_reg     <= '0;
                    dvld_reg     <= 1'b0;
                    hprev_reg    <= 1'b0;
                    found_reg[0] <= 1'b0;
                    found_reg[1] <= 1'b0;
                    state_reg    <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (scan_reg < count_reg)
                    begin
                        scan_reg <= scan_reg + CW'(1);
                        dvld_reg <= 1'b1;
                    end
                    else
                    begin
                        dvld_reg <= 1'b0;
                    end
                    if (dvld_reg)
                    begin
                        prev_reg  <= ram_rdata;
                        hprev_reg <= 1'b1;
                        if (hprev_reg)
                        begin
                            for (int k = 0; k < 2; k++)
                            begin
                                if (hit[k])
                                begin
                                    found_reg[k]  <= 1'b1;
                                    mpart_reg[k]  <= tsel[k][31:0] - seg_t0;
                                    mwhole_reg[k] <= seg_t1 - seg_t0;
                                    ma_x_reg[k]   <= prev_reg[15:0];
                                    ma_y_reg[k]   <= prev_reg[31:16];
                                    mb_x_reg[k]   <= ram_rdata[15:0];
                                    mb_y_reg[k]   <= ram_rdata[31:16];
                                end
                            end
                        end
                    end
                    else if (scan_reg == count_reg)
                    begin
                        job_reg   <= '0;
                        state_reg <= S_LGO;
                    end
                end
                S_LGO:
                begin
                    if (found_reg[jsel])
                    begin
                        state_reg <= S_LWAIT;
                    end
                    else
                    begin
                        res_reg[job_reg] <= '0;
                        job_reg          <= job_reg + 2'd1;
                        if (job_reg == 2'd3)
                        begin
                            state_reg <= S_IDLE;
                            done_reg  <= 1'b1;
                            pos_x_reg <= res_reg[0];
                            pos_y_reg <= res_reg[1];
                            vel_x_reg <= {res_reg[0][15], res_reg[0]}
                                       - {res_reg[2][15], res_reg[2]};
                            vel_y_reg <= {res_reg[1][15], res_reg[1]} - 17'd0;
                        end
                    end
                end
                S_LWAIT:
                begin
                    if (l_done)
                    begin
                        res_reg[job_reg] <= l_result;
                        job_reg          <= job_reg + 2'd1;
                        if (job_reg == 2'd3)
                        begin
                            state_reg <= S_IDLE;
                            done_reg  <= 1'b1;
                            pos_x_reg <= res_reg[0];
                            pos_y_reg <= res_reg[1];
                            vel_x_reg <= {res_reg[0][15], res_reg[0]}
                                       - {res_reg[2][15], res_reg[2]};
                            vel_y_reg <= {res_reg[1][15], res_reg[1]}
                                       - {l_result[15], l_result};
                        end
                        else
                        begin
                            state_reg <= S_LGO;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign vel_x        = vel_x_reg;
    assign vel_y        = vel_y_reg;
    assign have_drawing = hd_reg;
    assign status       = status_reg;

endmodule
